/* hw/rtl/crcfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the byte-wide CRC-16 (0x8005) update for the
// CRC-16 checked frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

	localparam logic [7:0]  HEADER_BYTE  = 8'hFF;
	localparam logic [7:0]  TRAILER_BYTE = 8'hFE;
	localparam logic [15:0] CRC_POLY     = 16'h8005;
	localparam logic [15:0] CRC_INIT     = 16'h0000;
	localparam int unsigned PAYLOAD_LEN  = 3;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_BAD_TRAILER = 2'd1,
		STATUS_BAD_CRC     = 2'd2
	} frame_status_t;

	typedef enum logic [7:0] {
		PH_HUNT    = 8'b0000_0001,
		PH_ID      = 8'b0000_0010,
		PH_PL0     = 8'b0000_0100,
		PH_PL1     = 8'b0000_1000,
		PH_PL2     = 8'b0001_0000,
		PH_CRC_HI  = 8'b0010_0000,
		PH_CRC_LO  = 8'b0100_0000,
		PH_TRAILER = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic          emit;
		frame_status_t status;
		logic [7:0]    track;
		logic [7:0]    heading;
		logic [7:0]    detect;
	} crcfr_res_t;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hw/rtl/crc16_frame_receiver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_frame_receiver_core
// Takes one received byte per cycle while in_stall is low and one result per
// completed frame. Frames are 0xFF, partner id, three payload bytes, CRC-16
// (0x8005, MSB first, init 0) high and low bytes over header, id and payload,
// then trailer 0xFE. A byte passes an input register, then the frame logic
// updates its state and CRC; a frame's result is registered in the result
// register when its trailer byte is stepped, and the CRC update is byte-wide.
// Only a stalled result with another result behind it holds the input side.
// partner_id may be written only while idle.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       partner_id_wr_en,
	input  logic [7:0] partner_id_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] frame_status,
	output logic [7:0] track_byte,
	output logic [7:0] heading_byte,
	output logic [7:0] detect_byte
);
	import crcfr_pkg::*;

	logic          [7:0] partner_id_q;
	logic                valid_s1;
	logic          [7:0] byte_s1;
	logic                advance;
	logic                step;
	crcfr_res_t          res;
	logic                out_valid_q;
	frame_status_t       status_q;
	logic          [7:0] track_q;
	logic          [7:0] heading_q;
	logic          [7:0] detect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partner_id_q <= 8'h00;
		end else if (partner_id_wr_en) begin
			partner_id_q <= partner_id_wr_data;
		end
	end

	assign advance  = !valid_s1 || !res.emit || !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	crcfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data       (byte_s1),
		.partner_id (partner_id_q),
		.res        (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			status_q  <= res.status;
			track_q   <= res.track;
			heading_q <= res.heading;
			detect_q  <= res.detect;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_status = status_q;
	assign track_byte   = track_q;
	assign heading_byte = heading_q;
	assign detect_byte  = detect_q;

	// a request held at the input always has a byte waiting in stage one
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && res.emit && out_valid_q))
		else $error("input stalled without a pending trailer");

	// a stepped trailer always yields a result request
	a_trailer_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.emit) |=> out_valid)
		else $error("trailer byte produced no result");

	// a new result only follows a stepped trailer
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(step && res.emit))
		else $error("result appeared without a trailer");

	// a stepped non-trailer byte never replaces a waiting result
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(track_byte) && $stable(frame_status)))
		else $error("stalled result changed");

endmodule

/* hw/rtl/crcfr_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_parser
// Frame state machine: header hunt, id check, payload capture, running CRC
// and trailer check. Presents the result of the byte being stepped.
// ----------------------------------------------------------------------------
module crcfr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data,
	input  logic [7:0]           partner_id,
	output crcfr_pkg::crcfr_res_t res
);
	import crcfr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic        crc_ok_q, crc_ok_d;
	logic [7:0]  pl_q [PAYLOAD_LEN];
	logic [7:0]  crc_hi_q;
	logic [15:0] crc_next;

	assign crc_next = crc16_byte(crc_q, data);

	always_comb begin
		phase_d  = phase_q;
		crc_d    = crc_q;
		crc_ok_d = crc_ok_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (data == HEADER_BYTE) begin
					crc_d   = crc16_byte(CRC_INIT, data);
					phase_d = PH_ID;
				end
			end
			PH_ID: begin
				if (data == partner_id) begin
					crc_d   = crc_next;
					phase_d = PH_PL0;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_PL0: begin
				crc_d   = crc_next;
				phase_d = PH_PL1;
			end
			PH_PL1: begin
				crc_d   = crc_next;
				phase_d = PH_PL2;
			end
			PH_PL2: begin
				crc_d   = crc_next;
				phase_d = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				crc_ok_d = (crc_hi_q == crc_q[15:8]) && (data == crc_q[7:0]);
				phase_d  = PH_TRAILER;
			end
			PH_TRAILER: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			crc_q    <= CRC_INIT;
			crc_ok_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			crc_ok_q <= crc_ok_d;
		end
	end

	// payload and received crc high byte, no reset
	always_ff @(posedge clk) begin
		if (step) begin
			if (phase_q == PH_PL0) begin
				pl_q[0] <= data;
			end
			if (phase_q == PH_PL1) begin
				pl_q[1] <= data;
			end
			if (phase_q == PH_PL2) begin
				pl_q[2] <= data;
			end
			if (phase_q == PH_CRC_HI) begin
				crc_hi_q <= data;
			end
		end
	end

	always_comb begin
		res.emit    = (phase_q == PH_TRAILER);
		res.track   = pl_q[0];
		res.heading = pl_q[1];
		res.detect  = pl_q[2];
		priority if (data != TRAILER_BYTE) begin
			res.status = STATUS_BAD_TRAILER;
		end else if (!crc_ok_q) begin
			res.status = STATUS_BAD_CRC;
		end else begin
			res.status = STATUS_OK;
		end
	end

endmodule
